// File: rtl/kfc_pkg.sv
package kfc_pkg;

    // Width of the calculator's working value.
    localparam int VALUE_BITS   = 16;
    localparam int KEY_BITS     = 5;
    localparam int KIND_BITS    = 2;
    localparam int FIELD_BITS   = 16;
    localparam int DIGIT_BITS   = 3;
    localparam int OPC_BITS     = 3;
    localparam int STEP_BITS    = 5;
    // The power-of-ten register never exceeds ten times the largest magnitude.
    localparam int POW_BITS     = VALUE_BITS + 4;
    localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

    // Translated key values.
    localparam logic [KEY_BITS-1:0] K_NONE  = 5'd0;
    localparam logic [KEY_BITS-1:0] K_ZERO  = 5'd10;
    localparam logic [KEY_BITS-1:0] K_ADD   = 5'd11;
    localparam logic [KEY_BITS-1:0] K_SUB   = 5'd12;
    localparam logic [KEY_BITS-1:0] K_MUL   = 5'd13;
    localparam logic [KEY_BITS-1:0] K_DIV   = 5'd14;
    localparam logic [KEY_BITS-1:0] K_EQ    = 5'd15;
    localparam logic [KEY_BITS-1:0] K_CLEAR = 5'd16;

    // Pending operation codes.
    localparam logic [OPC_BITS-1:0] ARITH_NONE = 3'd0;
    localparam logic [OPC_BITS-1:0] ARITH_ADD  = 3'd1;
    localparam logic [OPC_BITS-1:0] ARITH_SUB  = 3'd2;
    localparam logic [OPC_BITS-1:0] ARITH_MUL  = 3'd3;
    localparam logic [OPC_BITS-1:0] ARITH_DIV  = 3'd4;

    // Display kinds.
    localparam logic [KIND_BITS-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_ENTRY   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RESULT  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_CLEARED = 2'd3;

    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX   = 3'd7;
    localparam logic [DIGIT_BITS-1:0] SHOW_DIGITS = 3'd5;

    typedef enum logic [STEP_BITS-1:0] {
        S_FETCH,
        S_CHKREP,
        S_SETLAST,
        S_CHKCLR,
        S_CHKOP,
        S_CHKENT,
        S_CHKPEND,
        S_ARITH,
        S_DIVSTEP,
        S_DIVFIX,
        S_COMMIT,
        S_AFTER,
        S_OPLATCH,
        S_TOEMIT,
        S_EQSET,
        S_SHOW,
        S_DIGSTEP,
        S_DIGEND,
        S_EMIT,
        S_RETURN,
        S_DIGIT,
        S_CLR,
        S_EZ
    } step_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_SETLAST,
        UOP_ARITH,
        UOP_DIVSTEP,
        UOP_DIVFIX,
        UOP_COMMIT,
        UOP_LATCH,
        UOP_EQSET,
        UOP_DIGINIT,
        UOP_DIGSTEP,
        UOP_DIGEND,
        UOP_POST,
        UOP_DIGIT,
        UOP_CLEAR,
        UOP_EZ
    } uop_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_KEY,
        C_REPEAT,
        C_DIGIT,
        C_CLEAR,
        C_NOT_OP,
        C_ENTRY_ZERO,
        C_NO_PEND,
        C_NOT_DIV,
        C_DIV_MORE,
        C_IS_EQ,
        C_SHOWN,
        C_DIG_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } uword_t;

    // Raw scan code to key value; codes outside the keypad read as no key.
    function automatic logic [KEY_BITS-1:0] key_map(input logic [KEY_BITS-1:0] code);
        logic [KEY_BITS-1:0] tv;
        case (code)
            5'd1:    tv = 5'd7;
            5'd2:    tv = 5'd4;
            5'd3:    tv = 5'd1;
            5'd4:    tv = K_ZERO;
            5'd5:    tv = 5'd8;
            5'd6:    tv = 5'd5;
            5'd7:    tv = 5'd2;
            5'd8:    tv = K_CLEAR;
            5'd9:    tv = 5'd9;
            5'd10:   tv = 5'd6;
            5'd11:   tv = 5'd3;
            5'd12:   tv = K_EQ;
            5'd13:   tv = K_ADD;
            5'd14:   tv = K_SUB;
            5'd15:   tv = K_MUL;
            5'd16:   tv = K_DIV;
            default: tv = K_NONE;
        endcase
        return tv;
    endfunction

    // Control store: one word per step.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        unique case (s)
            S_FETCH:   w = '{UOP_NOP,     C_NO_KEY,     S_FETCH};
            S_CHKREP:  w = '{UOP_NOP,     C_REPEAT,     S_EMIT};
            S_SETLAST: w = '{UOP_SETLAST, C_DIGIT,      S_DIGIT};
            S_CHKCLR:  w = '{UOP_NOP,     C_CLEAR,      S_CLR};
            S_CHKOP:   w = '{UOP_NOP,     C_NOT_OP,     S_EMIT};
            S_CHKENT:  w = '{UOP_NOP,     C_ENTRY_ZERO, S_EZ};
            S_CHKPEND: w = '{UOP_NOP,     C_NO_PEND,    S_AFTER};
            S_ARITH:   w = '{UOP_ARITH,   C_NOT_DIV,    S_COMMIT};
            S_DIVSTEP: w = '{UOP_DIVSTEP, C_DIV_MORE,   S_DIVSTEP};
            S_DIVFIX:  w = '{UOP_DIVFIX,  C_NONE,       S_FETCH};
            S_COMMIT:  w = '{UOP_COMMIT,  C_NONE,       S_FETCH};
            S_AFTER:   w = '{UOP_NOP,     C_IS_EQ,      S_EQSET};
            S_OPLATCH: w = '{UOP_LATCH,   C_SHOWN,      S_SHOW};
            S_TOEMIT:  w = '{UOP_NOP,     C_ALWAYS,     S_EMIT};
            S_EQSET:   w = '{UOP_EQSET,   C_NONE,       S_FETCH};
            S_SHOW:    w = '{UOP_DIGINIT, C_NONE,       S_FETCH};
            S_DIGSTEP: w = '{UOP_DIGSTEP, C_DIG_MORE,   S_DIGSTEP};
            S_DIGEND:  w = '{UOP_DIGEND,  C_NONE,       S_FETCH};
            S_EMIT:    w = '{UOP_POST,    C_OUT_BUSY,   S_EMIT};
            S_RETURN:  w = '{UOP_NOP,     C_ALWAYS,     S_FETCH};
            S_DIGIT:   w = '{UOP_DIGIT,   C_ALWAYS,     S_EMIT};
            S_CLR:     w = '{UOP_CLEAR,   C_ALWAYS,     S_EMIT};
            S_EZ:      w = '{UOP_EZ,      C_ALWAYS,     S_EMIT};
            default:   w = '{UOP_NOP,     C_ALWAYS,     S_FETCH};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/keypad_four_function_calculator_top.sv
// Channel   Signals                                    Direction   Transfer when
// key       key_valid, key_ready, key_code             in          key_valid && key_ready
// result    result_valid, result_ready, display_kind,  out         result_valid && result_ready
//           shown_value, digit_count, too_big
//
// Each key item runs a microprogram, from a short path for a repeated key or a digit
// up to the longest path, for an operator or equals that completes a division.
// The longest path is the one-bit-per-cycle divide loop (VALUE_BITS steps)
// followed by the digit-count loop (one step per decimal digit, plus one to exit).
// Reset clears the step counter and the calculator state; no clearing pass.
// A new key is taken while the previous result still waits in the output register;
// the sequencer holds at its emit step only while that register holds a result not yet taken.
module keypad_four_function_calculator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                key_valid,
    output logic                                key_ready,
    input  logic [kfc_pkg::KEY_BITS-1:0]        key_code,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [kfc_pkg::KIND_BITS-1:0]       display_kind,
    output logic signed [kfc_pkg::FIELD_BITS-1:0] shown_value,
    output logic [kfc_pkg::DIGIT_BITS-1:0]      digit_count,
    output logic                                too_big
);
    import kfc_pkg::*;

    localparam int VB = VALUE_BITS;

    step_t                    step_reg, step_next;
    uword_t                   uw;
    logic                     take;
    logic [STEP_BITS-1:0]     step_inc;

    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [KEY_BITS-1:0]      last_reg, last_next;
    logic [OPC_BITS-1:0]      pend_reg, pend_next;
    logic [VB-1:0]            acc_reg, acc_next;
    logic [VB-1:0]            entry_reg, entry_next;
    logic [VB-1:0]            res_reg, res_next;
    logic                     shown_reg, shown_next;
    logic [VB-1:0]            quo_reg, quo_next;
    logic [VB-1:0]            rem_reg, rem_next;
    logic [VB-1:0]            dvs_reg, dvs_next;
    logic                     neg_reg, neg_next;
    logic [DIV_CNT_BITS-1:0]  div_cnt_reg, div_cnt_next;
    logic [VB-1:0]            mag_reg, mag_next;
    logic [POW_BITS-1:0]      pow_reg, pow_next;
    logic [DIGIT_BITS-1:0]    ndig_reg, ndig_next;
    logic [KIND_BITS-1:0]     w_kind_reg, w_kind_next;
    logic [VB-1:0]            w_value_reg, w_value_next;
    logic [DIGIT_BITS-1:0]    w_cnt_reg, w_cnt_next;
    logic                     w_big_reg, w_big_next;
    logic                     out_valid_reg, out_valid_next;
    logic [KIND_BITS-1:0]     out_kind_reg, out_kind_next;
    logic [FIELD_BITS-1:0]    out_value_reg, out_value_next;
    logic [DIGIT_BITS-1:0]    out_cnt_reg, out_cnt_next;
    logic                     out_big_reg, out_big_next;

    logic                     key_fire;
    logic                     out_busy;
    logic [KEY_BITS-1:0]      tv;
    logic                     is_digit;
    logic                     is_opeq;
    logic [KEY_BITS-1:0]      op_wide;
    logic [OPC_BITS-1:0]      new_op;
    logic [VB-1:0]            d_val;
    logic [VB-1:0]            entry_x10;
    logic [VB-1:0]            acc_mag;
    logic [VB-1:0]            entry_mag;
    logic [VB-1:0]            res_mag;
    logic [2*VB-1:0]          prod;
    logic [VB-1:0]            rem_sh;
    logic                     fits;
    logic [VB-1:0]            rem_sub;
    logic                     dig_more;
    logic [POW_BITS-1:0]      pow_x10;
    logic [VB+FIELD_BITS-1:0] value_wide;

    assign key_ready = (step_reg == S_FETCH);
    assign key_fire  = key_valid && key_ready;
    assign out_busy  = out_valid_reg && !result_ready;

    assign result_valid = out_valid_reg;
    assign display_kind = out_kind_reg;
    assign shown_value  = out_value_reg;
    assign digit_count  = out_cnt_reg;
    assign too_big      = out_big_reg;

    assign uw       = ucode(step_reg);
    assign tv       = key_map(key_reg);
    assign is_digit = (tv != K_NONE) && (tv <= K_ZERO);
    assign is_opeq  = (tv >= K_ADD) && (tv <= K_EQ);
    assign op_wide  = tv - K_ADD + 5'd1;
    assign new_op   = op_wide[OPC_BITS-1:0];

    assign d_val     = (tv == K_ZERO) ? '0 : VB'(tv);
    assign entry_x10 = (entry_reg << 3) + (entry_reg << 1) + d_val;

    assign acc_mag   = acc_reg[VB-1]   ? (~acc_reg + 1'b1)   : acc_reg;
    assign entry_mag = entry_reg[VB-1] ? (~entry_reg + 1'b1) : entry_reg;
    assign res_mag   = res_reg[VB-1]   ? (~res_reg + 1'b1)   : res_reg;
    assign prod      = {{VB{1'b0}}, acc_reg} * {{VB{1'b0}}, entry_reg};

    // Restoring divide on magnitudes; the remainder stays below the divisor,
    // so dropping its top bit on the shift loses nothing.
    assign rem_sh  = {rem_reg[VB-2:0], quo_reg[VB-1]};
    assign fits    = (rem_sh >= dvs_reg);
    assign rem_sub = rem_sh - dvs_reg;

    assign dig_more   = (POW_BITS'(mag_reg) >= pow_reg) && (ndig_reg != DIGIT_MAX);
    assign pow_x10    = (pow_reg << 3) + (pow_reg << 1);
    assign value_wide = {{FIELD_BITS{1'b0}}, w_value_reg};

    // Branch condition of the current control word.
    always_comb
    begin
        case (uw.cond)
            C_NONE:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_KEY:     take = !key_valid;
            C_REPEAT:     take = (key_reg == last_reg);
            C_DIGIT:      take = is_digit;
            C_CLEAR:      take = (tv == K_CLEAR);
            C_NOT_OP:     take = !is_opeq;
            C_ENTRY_ZERO: take = (entry_reg == '0);
            C_NO_PEND:    take = (pend_reg == ARITH_NONE);
            C_NOT_DIV:    take = (pend_reg != ARITH_DIV);
            C_DIV_MORE:   take = (div_cnt_reg != '0);
            C_IS_EQ:      take = (tv == K_EQ);
            C_SHOWN:      take = shown_reg;
            C_DIG_MORE:   take = dig_more;
            C_OUT_BUSY:   take = out_busy;
            default:      take = 1'b0;
        endcase
    end

    // Step counter: branch to the target or fall through.
    always_comb
    begin
        step_inc  = step_reg + 5'd1;
        step_next = take ? uw.target : step_t'(step_inc);
    end

    // Datapath driven by the micro-operation.
    always_comb
    begin
        key_next       = key_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        entry_next     = entry_reg;
        res_next       = res_reg;
        shown_next     = shown_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        div_cnt_next   = div_cnt_reg;
        mag_next       = mag_reg;
        pow_next       = pow_reg;
        ndig_next      = ndig_reg;
        w_kind_next    = w_kind_reg;
        w_value_next   = w_value_reg;
        w_cnt_next     = w_cnt_reg;
        w_big_next     = w_big_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_cnt_next   = out_cnt_reg;
        out_big_next   = out_big_reg;

        if (key_fire)
        begin
            key_next     = key_code;
            shown_next   = 1'b0;
            w_kind_next  = KIND_NONE;
            w_value_next = '0;
            w_cnt_next   = '0;
            w_big_next   = 1'b0;
        end

        unique case (uw.uop)
            UOP_NOP:
            begin
            end
            UOP_SETLAST:
            begin
                last_next = key_reg;
            end
            UOP_ARITH:
            begin
                case (pend_reg)
                    ARITH_ADD: res_next = acc_reg + entry_reg;
                    ARITH_SUB: res_next = acc_reg - entry_reg;
                    ARITH_MUL: res_next = prod[VB-1:0];
                    default:
                    begin
                        quo_next     = acc_mag;
                        rem_next     = '0;
                        dvs_next     = entry_mag;
                        neg_next     = acc_reg[VB-1] ^ entry_reg[VB-1];
                        div_cnt_next = DIV_CNT_BITS'(VB - 1);
                    end
                endcase
            end
            UOP_DIVSTEP:
            begin
                rem_next = fits ? rem_sub : rem_sh;
                quo_next = {quo_reg[VB-2:0], fits};
                if (div_cnt_reg != '0)
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            UOP_DIVFIX:
            begin
                res_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
            UOP_COMMIT:
            begin
                acc_next   = res_reg;
                entry_next = res_reg;
                pend_next  = ARITH_NONE;
                shown_next = 1'b1;
            end
            UOP_LATCH:
            begin
                pend_next  = new_op;
                acc_next   = entry_reg;
                entry_next = '0;
            end
            UOP_EQSET:
            begin
                res_next   = acc_reg;
                entry_next = acc_reg;
                pend_next  = ARITH_NONE;
            end
            UOP_DIGINIT:
            begin
                mag_next     = res_mag;
                pow_next     = POW_BITS'(1);
                ndig_next    = '0;
                w_kind_next  = KIND_RESULT;
                w_value_next = res_reg;
            end
            UOP_DIGSTEP:
            begin
                if (dig_more)
                begin
                    ndig_next = ndig_reg + 1'b1;
                    pow_next  = pow_x10;
                end
            end
            UOP_DIGEND:
            begin
                w_cnt_next = ndig_reg;
                w_big_next = (ndig_reg == '0) || (ndig_reg > SHOW_DIGITS);
            end
            UOP_POST:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = w_kind_reg;
                    out_value_next = value_wide[FIELD_BITS-1:0];
                    out_cnt_next   = w_cnt_reg;
                    out_big_next   = w_big_reg;
                end
            end
            UOP_DIGIT:
            begin
                entry_next   = entry_x10;
                w_kind_next  = KIND_ENTRY;
                w_value_next = entry_x10;
            end
            UOP_CLEAR:
            begin
                pend_next    = ARITH_NONE;
                acc_next     = '0;
                entry_next   = '0;
                w_kind_next  = KIND_CLEARED;
                w_value_next = '0;
            end
            UOP_EZ:
            begin
                if (tv != K_EQ)
                begin
                    pend_next = new_op;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_FETCH;
            last_reg      <= '0;
            pend_reg      <= ARITH_NONE;
            acc_reg       <= '0;
            entry_reg     <= '0;
            shown_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            last_reg      <= last_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            entry_reg     <= entry_next;
            shown_reg     <= shown_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        res_reg       <= res_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        pow_reg       <= pow_next;
        ndig_reg      <= ndig_next;
        w_kind_reg    <= w_kind_next;
        w_value_reg   <= w_value_next;
        w_cnt_reg     <= w_cnt_next;
        w_big_reg     <= w_big_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_cnt_reg   <= out_cnt_next;
        out_big_reg   <= out_big_next;
    end

    // Only a shown result carries a digit count or the too-big flag.
    a_digits_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (display_kind != KIND_RESULT) |-> (digit_count == '0) && !too_big)
        else $error("digit count or too-big flag on a result that is not shown");

    a_too_big_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (display_kind == KIND_RESULT)
        |-> too_big == ((digit_count == '0) || (digit_count > SHOW_DIGITS)))
        else $error("too-big flag disagrees with digit count");

    a_divide_only_for_div: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == S_DIVSTEP) |-> (pend_reg == ARITH_DIV))
        else $error("divide loop running without a pending division");

    a_key_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready |=> (step_reg == S_CHKREP))
        else $error("sequencer did not start after a key transfer");

    a_pending_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= ARITH_DIV)
        else $error("pending operation holds an unknown code");

endmodule

// File: sim/tb_keypad_four_function_calculator_top.sv
`timescale 1ns / 1ps

module tb_keypad_four_function_calculator_top;
    import kfc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1820;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_N        = 30;

    // Raw scan codes as the keypad delivers them.
    localparam logic [KEY_BITS-1:0] SC_NONE  = 5'd0;
    localparam logic [KEY_BITS-1:0] SC_D7    = 5'd1;
    localparam logic [KEY_BITS-1:0] SC_D4    = 5'd2;
    localparam logic [KEY_BITS-1:0] SC_D1    = 5'd3;
    localparam logic [KEY_BITS-1:0] SC_D0    = 5'd4;
    localparam logic [KEY_BITS-1:0] SC_D8    = 5'd5;
    localparam logic [KEY_BITS-1:0] SC_D5    = 5'd6;
    localparam logic [KEY_BITS-1:0] SC_D2    = 5'd7;
    localparam logic [KEY_BITS-1:0] SC_CLEAR = 5'd8;
    localparam logic [KEY_BITS-1:0] SC_D9    = 5'd9;
    localparam logic [KEY_BITS-1:0] SC_D6    = 5'd10;
    localparam logic [KEY_BITS-1:0] SC_D3    = 5'd11;
    localparam logic [KEY_BITS-1:0] SC_EQ    = 5'd12;
    localparam logic [KEY_BITS-1:0] SC_ADD   = 5'd13;
    localparam logic [KEY_BITS-1:0] SC_SUB   = 5'd14;
    localparam logic [KEY_BITS-1:0] SC_MUL   = 5'd15;
    localparam logic [KEY_BITS-1:0] SC_DIV   = 5'd16;
    localparam logic [KEY_BITS-1:0] SC_FIRST_BAD = 5'd17;
    localparam logic [KEY_BITS-1:0] SC_LAST_BAD  = 5'd31;

    localparam logic [KEY_BITS-1:0] DIGIT_SC [10] = '{SC_D0, SC_D1, SC_D2, SC_D3, SC_D4,
                                                      SC_D5, SC_D6, SC_D7, SC_D8, SC_D9};
    localparam logic [KEY_BITS-1:0] OPER_SC [4] = '{SC_ADD, SC_SUB, SC_MUL, SC_DIV};

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] value;
        logic [DIGIT_BITS-1:0] digits;
        logic                  big;
    } disp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] code;
        logic                typed;
        disp_t               want;
    } dir_row_t;

    localparam disp_t NO_CHANGE = '0;
    localparam disp_t CLEARED   = '{KIND_CLEARED, 16'h0000, 3'd0, 1'b0};

    logic                          clk;
    logic                          rst_n;
    logic                          key_valid;
    logic                          key_ready;
    logic [KEY_BITS-1:0]           key_code;
    logic                          result_valid;
    logic                          result_ready;
    logic [KIND_BITS-1:0]          display_kind;
    logic signed [FIELD_BITS-1:0]  shown_value;
    logic [DIGIT_BITS-1:0]         digit_count;
    logic                          too_big;

    // Calculator state as the testbench sees it.
    logic [KEY_BITS-1:0]   calc_last;
    logic [OPC_BITS-1:0]   calc_op;
    logic [VALUE_BITS-1:0] calc_acc;
    logic [VALUE_BITS-1:0] calc_entry;

    disp_t    display_q [$];
    dir_row_t dir_rows [DIR_N];
    int       mismatch_count;
    int       cycle_count;

    keypad_four_function_calculator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_ready    (key_ready),
        .key_code     (key_code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .display_kind (display_kind),
        .shown_value  (shown_value),
        .digit_count  (digit_count),
        .too_big      (too_big)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic logic [KEY_BITS-1:0] scan_to_key(input logic [KEY_BITS-1:0] code);
        case (code)
            SC_D1:    return 5'd1;
            SC_D2:    return 5'd2;
            SC_D3:    return 5'd3;
            SC_D4:    return 5'd4;
            SC_D5:    return 5'd5;
            SC_D6:    return 5'd6;
            SC_D7:    return 5'd7;
            SC_D8:    return 5'd8;
            SC_D9:    return 5'd9;
            SC_D0:    return K_ZERO;
            SC_CLEAR: return K_CLEAR;
            SC_EQ:    return K_EQ;
            SC_ADD:   return K_ADD;
            SC_SUB:   return K_SUB;
            SC_MUL:   return K_MUL;
            SC_DIV:   return K_DIV;
            default:  return K_NONE;
        endcase
    endfunction

    function automatic logic [OPC_BITS-1:0] op_for_key(input logic [KEY_BITS-1:0] kv);
        case (kv)
            K_ADD:   return ARITH_ADD;
            K_SUB:   return ARITH_SUB;
            K_MUL:   return ARITH_MUL;
            default: return ARITH_DIV;
        endcase
    endfunction

    function automatic logic [VALUE_BITS-1:0] arith_apply(input logic [OPC_BITS-1:0] op,
                                                          input logic [VALUE_BITS-1:0] a,
                                                          input logic [VALUE_BITS-1:0] b);
        int sa;
        int sb;
        int q;
        sa = $signed(a);
        sb = $signed(b);
        case (op)
            ARITH_ADD: return a + b;
            ARITH_SUB: return a - b;
            ARITH_MUL: return a * b;
            ARITH_DIV:
            begin
                if (sb == 0)
                    return a;
                // Computed at full integer width so that the most negative value
                // divided by minus one wraps back onto itself.
                q = sa / sb;
                return q[VALUE_BITS-1:0];
            end
            default:   return a;
        endcase
    endfunction

    function automatic disp_t result_display(input logic [VALUE_BITS-1:0] r);
        int    t;
        int    n;
        disp_t d;
        t = $signed(r);
        n = 0;
        while (t != 0)
        begin
            t = t / 10;
            n++;
        end
        d.kind   = KIND_RESULT;
        d.value  = r;
        d.digits = (n > int'(DIGIT_MAX)) ? DIGIT_MAX : n[DIGIT_BITS-1:0];
        d.big    = (n == 0) || (n > int'(SHOW_DIGITS));
        return d;
    endfunction

    task automatic press_key(input logic [KEY_BITS-1:0] code, output disp_t d);
        logic [KEY_BITS-1:0] kv;
        logic                shown;
        d     = NO_CHANGE;
        shown = 1'b0;
        if (code != calc_last)
        begin
            calc_last = code;
            kv = scan_to_key(code);
            if (kv >= 5'd1 && kv <= K_ZERO)
            begin
                calc_entry = calc_entry * 16'd10 + ((kv == K_ZERO) ? 16'd0 : {11'd0, kv});
                d.kind  = KIND_ENTRY;
                d.value = calc_entry;
            end
            else if (kv == K_CLEAR)
            begin
                calc_op    = ARITH_NONE;
                calc_acc   = '0;
                calc_entry = '0;
                d          = CLEARED;
            end
            else if (kv >= K_ADD)
            begin
                if (calc_entry != '0)
                begin
                    if (calc_op != ARITH_NONE)
                    begin
                        calc_acc   = arith_apply(calc_op, calc_acc, calc_entry);
                        calc_entry = calc_acc;
                        calc_op    = ARITH_NONE;
                        d          = result_display(calc_acc);
                        shown      = 1'b1;
                    end
                    if (kv == K_EQ)
                    begin
                        if (!shown)
                            d = result_display(calc_acc);
                        calc_entry = calc_acc;
                        calc_op    = ARITH_NONE;
                    end
                    else
                    begin
                        calc_op    = op_for_key(kv);
                        calc_acc   = calc_entry;
                        calc_entry = '0;
                    end
                end
                else if (kv != K_EQ)
                begin
                    calc_op = op_for_key(kv);
                end
            end
        end
    endtask

    // Mostly keypad-like traffic; some releases, repeats and codes off the keypad.
    function automatic logic [KEY_BITS-1:0] random_code(input logic [KEY_BITS-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return DIGIT_SC[$urandom_range(0, 9)];
        else if (r < 52)
            return SC_NONE;
        else if (r < 68)
            return OPER_SC[$urandom_range(0, 3)];
        else if (r < 80)
            return SC_EQ;
        else if (r < 84)
            return SC_CLEAR;
        else if (r < 88)
            return prev;
        else if (r < 93)
            return KEY_BITS'($urandom_range(int'(SC_FIRST_BAD), int'(SC_LAST_BAD)));
        else
            return KEY_BITS'($urandom_range(0, int'(SC_LAST_BAD)));
    endfunction

    task automatic offer_key(input logic [KEY_BITS-1:0] code, input logic typed,
                             input disp_t want, input int seq);
        int    gap;
        disp_t predicted;
        gap = ((seq / 150) % 4 == 2) ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap != 0)
        begin
            key_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        key_valid <= 1'b1;
        key_code  <= code;
        press_key(code, predicted);
        display_q.push_back(typed ? want : predicted);
        do
            @(posedge clk);
        while (!key_ready);
    endtask

    initial
    begin
        logic [KEY_BITS-1:0] prev_code;
        key_valid  = 1'b0;
        key_code   = SC_NONE;
        calc_last  = SC_NONE;
        calc_op    = ARITH_NONE;
        calc_acc   = '0;
        calc_entry = '0;
        prev_code  = SC_NONE;

        dir_rows[0]  = '{SC_NONE,  1'b1, NO_CHANGE};
        dir_rows[1]  = '{SC_D0,    1'b1, '{KIND_ENTRY, 16'h0000, 3'd0, 1'b0}};
        dir_rows[2]  = '{SC_LAST_BAD, 1'b1, NO_CHANGE};
        dir_rows[3]  = '{SC_D1,    1'b1, '{KIND_ENTRY, 16'h0001, 3'd0, 1'b0}};
        dir_rows[4]  = '{SC_SUB,   1'b1, NO_CHANGE};
        dir_rows[5]  = '{SC_D2,    1'b1, '{KIND_ENTRY, 16'h0002, 3'd0, 1'b0}};
        dir_rows[6]  = '{SC_EQ,    1'b1, '{KIND_RESULT, 16'hFFFF, 3'd1, 1'b0}};
        dir_rows[7]  = '{SC_EQ,    1'b1, NO_CHANGE};
        dir_rows[8]  = '{SC_CLEAR, 1'b1, CLEARED};
        dir_rows[9]  = '{SC_EQ,    1'b1, NO_CHANGE};
        dir_rows[10] = '{SC_ADD,   1'b1, NO_CHANGE};
        // Entry of 32768, which wraps to the most negative value.
        dir_rows[11] = '{SC_D3,    1'b0, NO_CHANGE};
        dir_rows[12] = '{SC_D2,    1'b0, NO_CHANGE};
        dir_rows[13] = '{SC_D7,    1'b0, NO_CHANGE};
        dir_rows[14] = '{SC_D6,    1'b0, NO_CHANGE};
        dir_rows[15] = '{SC_D8,    1'b0, NO_CHANGE};
        dir_rows[16] = '{SC_DIV,   1'b1, '{KIND_RESULT, 16'h8000, 3'd5, 1'b0}};
        // Entry of 65535, read as minus one.
        dir_rows[17] = '{SC_D6,    1'b0, NO_CHANGE};
        dir_rows[18] = '{SC_D5,    1'b0, NO_CHANGE};
        dir_rows[19] = '{SC_NONE,  1'b1, NO_CHANGE};
        dir_rows[20] = '{SC_D5,    1'b0, NO_CHANGE};
        dir_rows[21] = '{SC_D3,    1'b0, NO_CHANGE};
        dir_rows[22] = '{SC_D5,    1'b0, NO_CHANGE};
        dir_rows[23] = '{SC_EQ,    1'b1, '{KIND_RESULT, 16'h8000, 3'd5, 1'b0}};
        dir_rows[24] = '{SC_MUL,   1'b1, NO_CHANGE};
        dir_rows[25] = '{SC_CLEAR, 1'b1, CLEARED};
        dir_rows[26] = '{SC_D1,    1'b0, NO_CHANGE};
        dir_rows[27] = '{SC_SUB,   1'b1, NO_CHANGE};
        dir_rows[28] = '{SC_D1,    1'b0, NO_CHANGE};
        dir_rows[29] = '{SC_EQ,    1'b1, '{KIND_RESULT, 16'h0000, 3'd0, 1'b1}};

        wait (rst_n === 1'b1);
        @(posedge clk);
        for (int i = 0; i < DIR_N; i++)
            offer_key(dir_rows[i].code, dir_rows[i].typed, dir_rows[i].want, i);
        prev_code = dir_rows[DIR_N-1].code;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            logic [KEY_BITS-1:0] code;
            code = random_code(prev_code);
            offer_key(code, 1'b0, NO_CHANGE, DIR_N + i);
            prev_code = code;
        end
        @(negedge clk);
        key_valid <= 1'b0;

        while (display_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && display_q.size() == 0)
            $display("keypad_four_function_calculator_top verification clean");
        else
            $display("keypad_four_function_calculator_top verification failed");
        $finish;
    end

    // Result side: random stalls, calm stretches, and one long hold-off that
    // backs the block up until it refuses new keys.
    initial
    begin
        int  stall;
        int  taken;
        logic held;
        result_ready = 1'b0;
        taken        = 0;
        held         = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == HOLD_AT && !held)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            else
            begin
                stall = ((taken / 120) % 4 == 3) ? 0 : $urandom_range(0, 8);
            end
            @(negedge clk);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        disp_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (display_q.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected result transfer: kind %0d value %0d digits %0d big %0d",
                             display_kind, shown_value, digit_count, too_big);
                mismatch_count++;
            end
            else
            begin
                want = display_q.pop_front();
                if (display_kind !== want.kind || shown_value !== want.value ||
                    digit_count !== want.digits || too_big !== want.big)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display({"result mismatch: kind %0d/%0d value %0d/%0d ",
                                  "digits %0d/%0d big %0d/%0d (expected/actual)"},
                                 want.kind, display_kind, $signed(want.value), shown_value,
                                 want.digits, digit_count, want.big, too_big);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("keypad_four_function_calculator_top verification failed");
            $finish;
        end
    end

endmodule
